[rtl/ccm_pkg.sv]
package ccm_pkg;

	localparam int APB_ADDR_W    = 4;
	localparam int NUM_POINTS_W  = 9;
	localparam int NUM_CLASSES_W = 4;
	localparam int CNT_CMP_W     = 13;

	localparam logic [1:0] REG_NUM_POINTS  = 2'd0;
	localparam logic [1:0] REG_NUM_CLASSES = 2'd1;
	localparam logic [1:0] REG_TRANSPOSE   = 2'd2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] x_value;
		logic [15:0]        class_prob;
		logic [15:0]        sqrt_prob;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] y_value;
		logic               last;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic sum_rd;
		logic ed_rd;
		logic prep;
		logic mul;
		logic mul_rd;
		logic rnd;
		logic ld_wr;
		logic rd_out;
		logic first;
		logic last;
	} ccm_cmd_t;

	typedef struct packed {
		logic out_free;
	} ccm_sts_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               hit;
	} sat32_t;

	function automatic sat32_t sat32(input logic signed [43:0] v);
		sat32_t r;
		r.hit = 1'b0;
		r.val = 32'(v);
		if (v > 44'sd2147483647) begin
			r.val = 32'sh7FFFFFFF;
			r.hit = 1'b1;
		end else if (v < -44'sd2147483648) begin
			r.val = 32'sh80000000;
			r.hit = 1'b1;
		end
		return r;
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
		logic signed [39:0] r;
		r = 40'(v);
		if (v > 42'sd549755813887) begin
			r = 40'sh7FFFFFFFFF;
		end else if (v < -42'sd549755813888) begin
			r = 40'sh8000000000;
		end
		return r;
	endfunction

	function automatic logic signed [42:0] q15_round(input logic signed [57:0] v);
		logic signed [57:0] t;
		t = v + 58'sd16384;
		return 43'(t >>> 15);
	endfunction

endpackage

[rtl/ccm_stream_if.sv]
interface ccm_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

[rtl/ccm_regs.sv]
module ccm_regs #(
	parameter int MAX_POINTS  = 256,
	parameter int MAX_CLASSES = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ccm_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	output logic [ccm_pkg::NUM_POINTS_W-1:0]     num_points,
	output logic [ccm_pkg::NUM_CLASSES_W-1:0]    num_classes,
	output logic                                 transpose,
	output logic                                 cfg_wr
);

	localparam int NP_MAX = (1 << ccm_pkg::NUM_POINTS_W) - 1;
	localparam int NC_MAX = (1 << ccm_pkg::NUM_CLASSES_W) - 1;
	localparam int NP_LIM = (MAX_POINTS > NP_MAX) ? NP_MAX : MAX_POINTS;
	localparam int NC_LIM = (MAX_CLASSES > NC_MAX) ? NC_MAX : MAX_CLASSES;

	logic [1:0]                       idx;
	logic                             wr;
	logic [ccm_pkg::NUM_POINTS_W-1:0]  np_wr;
	logic [ccm_pkg::NUM_CLASSES_W-1:0] nc_wr;
	logic [ccm_pkg::NUM_POINTS_W-1:0]  num_points_q;
	logic [ccm_pkg::NUM_CLASSES_W-1:0] num_classes_q;
	logic                             transpose_q;

	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		np_wr = pwdata[ccm_pkg::NUM_POINTS_W-1:0];
		if (np_wr == '0) begin
			np_wr = ccm_pkg::NUM_POINTS_W'(1);
		end else if (np_wr > ccm_pkg::NUM_POINTS_W'(NP_LIM)) begin
			np_wr = ccm_pkg::NUM_POINTS_W'(NP_LIM);
		end
		nc_wr = pwdata[ccm_pkg::NUM_CLASSES_W-1:0];
		if (nc_wr == '0) begin
			nc_wr = ccm_pkg::NUM_CLASSES_W'(1);
		end else if (nc_wr > ccm_pkg::NUM_CLASSES_W'(NC_LIM)) begin
			nc_wr = ccm_pkg::NUM_CLASSES_W'(NC_LIM);
		end
	end

	always_comb begin
		cfg_wr = 1'b0;
		prdata = '0;
		case (idx)
			ccm_pkg::REG_NUM_POINTS: begin
				cfg_wr = wr;
				prdata = 32'(num_points_q);
			end
			ccm_pkg::REG_NUM_CLASSES: begin
				cfg_wr = wr;
				prdata = 32'(num_classes_q);
			end
			ccm_pkg::REG_TRANSPOSE: begin
				cfg_wr = wr;
				prdata = 32'(transpose_q);
			end
			default: begin
				cfg_wr = 1'b0;
				prdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q  <= ccm_pkg::NUM_POINTS_W'(1);
			num_classes_q <= ccm_pkg::NUM_CLASSES_W'(1);
			transpose_q   <= 1'b0;
		end else if (wr) begin
			case (idx)
				ccm_pkg::REG_NUM_POINTS:  num_points_q  <= np_wr;
				ccm_pkg::REG_NUM_CLASSES: num_classes_q <= nc_wr;
				ccm_pkg::REG_TRANSPOSE:   transpose_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign num_points  = num_points_q;
	assign num_classes = num_classes_q;
	assign transpose   = transpose_q;

endmodule

[rtl/ccm_ctrl.sv]
module ccm_ctrl #(
	parameter int MAX_POINTS  = 256,
	parameter int MAX_CLASSES = 8,
	localparam int DEPTH = MAX_POINTS * MAX_CLASSES,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_cmd,
	output logic                              in_ready,
	input  logic                              cfg_wr,
	input  logic [ccm_pkg::NUM_POINTS_W-1:0]  num_points,
	input  logic [ccm_pkg::NUM_CLASSES_W-1:0] num_classes,
	input  ccm_pkg::ccm_sts_t                 sts,
	output ccm_pkg::ccm_cmd_t                 cmd,
	output logic [AW-1:0]                     addr,
	output logic [PW-1:0]                     pt
);

	localparam int CMPW = ccm_pkg::CNT_CMP_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD_MUL,
		S_LD_RND,
		S_LD_ACC,
		S_RD_MEM,
		S_RD_PREP,
		S_RD_MUL,
		S_RD_RND,
		S_RD_OUT
	} state_t;

	state_t        state_q;
	logic [AW-1:0] ld_idx_q;
	logic [PW-1:0] ld_pt_q;
	logic [CW-1:0] ld_cls_q;
	logic [AW-1:0] rd_idx_q;
	logic [PW-1:0] rd_pt_q;
	logic [CW-1:0] rd_cls_q;
	logic          loaded_q;
	logic [AW-1:0] op_addr_q;
	logic [PW-1:0] op_pt_q;
	logic          op_first_q;
	logic          op_last_q;
	logic          accept;
	logic          ld_pt_end;
	logic          ld_last;
	logic          rd_pt_end;
	logic          rd_last;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign ld_pt_end = (CMPW'(ld_pt_q) + CMPW'(1) == CMPW'(num_points));
	assign ld_last   = ld_pt_end && (CMPW'(ld_cls_q) + CMPW'(1) == CMPW'(num_classes));
	assign rd_pt_end = (CMPW'(rd_pt_q) + CMPW'(1) == CMPW'(num_points));
	assign rd_last   = rd_pt_end && (CMPW'(rd_cls_q) + CMPW'(1) == CMPW'(num_classes));

	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		cmd.first   = op_first_q;
		cmd.last    = op_last_q;
		case (state_q)
			S_LD_MUL: begin
				cmd.sum_rd = 1'b1;
				cmd.mul    = 1'b1;
			end
			S_LD_RND:  cmd.rnd = 1'b1;
			S_LD_ACC:  cmd.ld_wr = 1'b1;
			S_RD_MEM: begin
				cmd.sum_rd = 1'b1;
				cmd.ed_rd  = 1'b1;
			end
			S_RD_PREP: cmd.prep = 1'b1;
			S_RD_MUL: begin
				cmd.mul    = 1'b1;
				cmd.mul_rd = 1'b1;
			end
			S_RD_RND:  cmd.rnd = 1'b1;
			S_RD_OUT:  cmd.rd_out = sts.out_free;
			default: ;
		endcase
	end

	assign addr = op_addr_q;
	assign pt   = op_pt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ld_idx_q   <= '0;
			ld_pt_q    <= '0;
			ld_cls_q   <= '0;
			rd_idx_q   <= '0;
			rd_pt_q    <= '0;
			rd_cls_q   <= '0;
			loaded_q   <= 1'b0;
			op_addr_q  <= '0;
			op_pt_q    <= '0;
			op_first_q <= 1'b0;
			op_last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && in_cmd == ccm_pkg::CMD_LOAD) begin
						op_addr_q  <= ld_idx_q;
						op_pt_q    <= ld_pt_q;
						op_first_q <= (ld_cls_q == '0);
						op_last_q  <= ld_last;
						if (ld_idx_q == '0) begin
							rd_idx_q <= '0;
							rd_pt_q  <= '0;
							rd_cls_q <= '0;
							loaded_q <= 1'b0;
						end
						if (ld_last) begin
							ld_idx_q <= '0;
							ld_pt_q  <= '0;
							ld_cls_q <= '0;
							loaded_q <= 1'b1;
						end else begin
							ld_idx_q <= ld_idx_q + AW'(1);
							if (ld_pt_end) begin
								ld_pt_q  <= '0;
								ld_cls_q <= ld_cls_q + CW'(1);
							end else begin
								ld_pt_q <= ld_pt_q + PW'(1);
							end
						end
						state_q <= S_LD_MUL;
					end else if (accept && loaded_q) begin
						op_addr_q  <= rd_idx_q;
						op_pt_q    <= rd_pt_q;
						op_first_q <= 1'b0;
						op_last_q  <= rd_last;
						if (rd_last) begin
							rd_idx_q <= '0;
							rd_pt_q  <= '0;
							rd_cls_q <= '0;
						end else begin
							rd_idx_q <= rd_idx_q + AW'(1);
							if (rd_pt_end) begin
								rd_pt_q  <= '0;
								rd_cls_q <= rd_cls_q + CW'(1);
							end else begin
								rd_pt_q <= rd_pt_q + PW'(1);
							end
						end
						state_q <= S_RD_MEM;
					end
				end
				S_LD_MUL:  state_q <= S_LD_RND;
				S_LD_RND:  state_q <= S_LD_ACC;
				S_LD_ACC:  state_q <= S_IDLE;
				S_RD_MEM:  state_q <= S_RD_PREP;
				S_RD_PREP: state_q <= S_RD_MUL;
				S_RD_MUL:  state_q <= S_RD_RND;
				S_RD_RND:  state_q <= S_RD_OUT;
				S_RD_OUT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_wr) begin
				ld_idx_q <= '0;
				ld_pt_q  <= '0;
				ld_cls_q <= '0;
				rd_idx_q <= '0;
				rd_pt_q  <= '0;
				rd_cls_q <= '0;
				loaded_q <= 1'b0;
			end
		end
	end

	a_rd_idle_until_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		!loaded_q |-> rd_idx_q == '0)
		else $error("read index moved without a complete vector");

	a_loaded_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(loaded_q) |-> $past(accept && in_cmd == ccm_pkg::CMD_LOAD))
		else $error("vector marked loaded without a load item");

	a_first_block_idx: assert property (@(posedge clk) disable iff (!arst_n)
		ld_cls_q == '0 |-> ld_idx_q == AW'(ld_pt_q))
		else $error("load index and point counter disagree in first class block");

	a_pt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(ld_pt_q) < CMPW'(num_points) && CMPW'(rd_pt_q) < CMPW'(num_points))
		else $error("point counter beyond num_points");

endmodule

[rtl/ccm_datapath.sv]
module ccm_datapath #(
	parameter int MAX_POINTS  = 256,
	parameter int MAX_CLASSES = 8,
	localparam int DEPTH = MAX_POINTS * MAX_CLASSES,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ccm_pkg::ccm_cmd_t   cmd,
	output ccm_pkg::ccm_sts_t   sts,
	input  logic                transpose,
	input  logic [AW-1:0]       addr,
	input  logic [PW-1:0]       pt,
	input  ccm_pkg::in_item_t   in_item,
	output ccm_pkg::out_item_t  out_item,
	output logic                out_valid,
	input  logic                out_ready
);

	logic signed [31:0] elem_mem [DEPTH];
	logic [15:0]        coef_mem [DEPTH];
	logic signed [39:0] sum_mem  [MAX_POINTS];

	logic signed [31:0] x_q;
	logic [15:0]        p_q;
	logic [15:0]        s_q;
	logic signed [31:0] e_rd_q;
	logic [15:0]        c_rd_q;
	logic signed [39:0] sum_rd_q;
	logic signed [40:0] opnd_q;
	logic signed [57:0] prod_q;
	logic signed [42:0] rnd_q;
	ccm_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic signed [40:0] mul_a;
	logic [15:0]        mul_b;
	ccm_pkg::sat32_t    u_sat;
	logic signed [40:0] add_val;
	logic signed [39:0] base;
	logic signed [39:0] sum_new;
	logic signed [43:0] y_full;
	ccm_pkg::sat32_t    y_sat;

	assign mul_a = cmd.mul_rd ? opnd_q : 41'(x_q);
	assign mul_b = cmd.mul_rd ? c_rd_q : (transpose ? p_q : s_q);

	assign u_sat   = ccm_pkg::sat32(44'(rnd_q));
	assign add_val = transpose ? 41'(rnd_q) : 41'(u_sat.val);
	assign base    = cmd.first ? 40'sd0 : sum_rd_q;
	assign sum_new = ccm_pkg::sat40(42'(base) + 42'(add_val));

	assign y_full = transpose ? 44'(rnd_q) : 44'(e_rd_q) - 44'(rnd_q);
	assign y_sat  = ccm_pkg::sat32(y_full);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q <= in_item.x_value;
			p_q <= in_item.class_prob;
			s_q <= in_item.sqrt_prob;
		end
		if (cmd.sum_rd) begin
			sum_rd_q <= sum_mem[pt];
		end
		if (cmd.ed_rd) begin
			e_rd_q <= elem_mem[addr];
			c_rd_q <= coef_mem[addr];
		end
		if (cmd.prep) begin
			opnd_q <= transpose ? 41'(e_rd_q) - 41'(sum_rd_q) : 41'(sum_rd_q);
		end
		if (cmd.mul) begin
			prod_q <= mul_a * $signed({1'b0, mul_b});
		end
		if (cmd.rnd) begin
			rnd_q <= ccm_pkg::q15_round(prod_q);
		end
		if (cmd.ld_wr) begin
			sum_mem[pt]    <= sum_new;
			elem_mem[addr] <= transpose ? x_q : u_sat.val;
			coef_mem[addr] <= transpose ? s_q : p_q;
		end
		if (cmd.rd_out) begin
			out_q.y_value   <= y_sat.val;
			out_q.saturated <= y_sat.hit;
			out_q.last      <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_item     = out_q;
	assign out_valid    = out_valid_q;

endmodule

[rtl/class_centered_matvec.sv]
// Class-centered matrix-vector product over a vector of num_points * num_classes
// Q16.16 elements in class-major order. Load items (cmd 0) store each element and
// accumulate its per-point sum; once the whole vector is in, read items (cmd 1)
// return one result each in load order, with last on the final one, and wrap.
// Load and read items run one at a time, a read also waiting for the output
// register to drain, through a single 41x17 multiplier and rounding stage with
// registered reads of the element, coefficient and point-sum memories. Point sums
// need no clearing pass: the first class block of every load overwrites them.
// Reads issued before a full load give no result, and a write to any of the three
// configuration registers restarts the vector.
module class_centered_matvec #(
	parameter int MAX_POINTS  = 256,
	parameter int MAX_CLASSES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ccm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	ccm_stream_if.sink                      stream_in,
	ccm_stream_if.source                    stream_out
);

	localparam int DEPTH = MAX_POINTS * MAX_CLASSES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	logic [ccm_pkg::NUM_POINTS_W-1:0]  num_points;
	logic [ccm_pkg::NUM_CLASSES_W-1:0] num_classes;
	logic                             transpose;
	logic                             cfg_wr;
	ccm_pkg::ccm_cmd_t                cmd;
	ccm_pkg::ccm_sts_t                sts;
	logic [AW-1:0]                    addr;
	logic [PW-1:0]                    pt;
	ccm_pkg::in_item_t                in_item;
	ccm_pkg::out_item_t               out_item;

	assign in_item            = stream_in.payload;
	assign stream_out.payload = out_item;

	ccm_regs #(
		.MAX_POINTS  (MAX_POINTS),
		.MAX_CLASSES (MAX_CLASSES)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.num_points  (num_points),
		.num_classes (num_classes),
		.transpose   (transpose),
		.cfg_wr      (cfg_wr)
	);

	ccm_ctrl #(
		.MAX_POINTS  (MAX_POINTS),
		.MAX_CLASSES (MAX_CLASSES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (stream_in.valid),
		.in_cmd      (in_item.cmd),
		.in_ready    (stream_in.ready),
		.cfg_wr      (cfg_wr),
		.num_points  (num_points),
		.num_classes (num_classes),
		.sts         (sts),
		.cmd         (cmd),
		.addr        (addr),
		.pt          (pt)
	);

	ccm_datapath #(
		.MAX_POINTS  (MAX_POINTS),
		.MAX_CLASSES (MAX_CLASSES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.transpose   (transpose),
		.addr        (addr),
		.pt          (pt),
		.in_item     (in_item),
		.out_item    (out_item),
		.out_valid   (stream_out.valid),
		.out_ready   (stream_out.ready)
	);

endmodule

[tb/ccm_result_checker.sv]
`timescale 1ns / 100ps

module ccm_result_checker #(
	parameter int MAX_POINTS  = 256,
	parameter int MAX_CLASSES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ccm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	input  logic                           pready,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  ccm_pkg::in_item_t              in_item,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  ccm_pkg::out_item_t             out_item,
	output int                             pending,
	output int                             failures
);

	localparam int     STORE_DEPTH = MAX_POINTS * MAX_CLASSES;
	localparam longint Y_HI        = 64'sd2147483647;
	localparam longint Y_LO        = -64'sd2147483648;
	localparam longint SUM_HI      = 64'sd549755813887;
	localparam longint SUM_LO      = -64'sd549755813888;

	logic signed [31:0] elem_mem [STORE_DEPTH];
	logic [15:0]        coef_mem [STORE_DEPTH];
	longint             point_acc [MAX_POINTS];
	int                 pts;
	int                 cls;
	logic               xpose;
	int                 load_pos;
	int                 read_pos;
	logic               vec_full;
	ccm_pkg::out_item_t owed[$];
	int                 err_cnt = 0;

	function automatic longint round_q15(input longint v);
		return (v + 64'sd16384) >>> 15;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	task automatic restart_vector();
		load_pos = 0;
		read_pos = 0;
		vec_full = 1'b0;
	endtask

	task automatic write_setting(input logic [1:0] idx, input logic [31:0] value);
		int v;
		if (idx == ccm_pkg::REG_NUM_POINTS) begin
			v = int'(value[8:0]);
			pts = (v < 1) ? 1 : (v > MAX_POINTS) ? MAX_POINTS : v;
		end else if (idx == ccm_pkg::REG_NUM_CLASSES) begin
			v = int'(value[3:0]);
			cls = (v < 1) ? 1 : (v > MAX_CLASSES) ? MAX_CLASSES : v;
		end else if (idx == ccm_pkg::REG_TRANSPOSE) begin
			xpose = value[0];
		end else begin
			return;
		end
		restart_vector();
	endtask

	task automatic take_load(input ccm_pkg::in_item_t it);
		longint x;
		longint u;
		longint add;
		int     pt;
		x = longint'($signed(it.x_value));
		if (load_pos == 0) begin
			foreach (point_acc[i]) point_acc[i] = 0;
			read_pos = 0;
			vec_full = 1'b0;
		end
		if (load_pos >= pts * cls || load_pos >= STORE_DEPTH) begin
			restart_vector();
			return;
		end
		pt = load_pos % pts;
		if (!xpose) begin
			u = clamp(round_q15(x * longint'(it.sqrt_prob)), Y_LO, Y_HI);
			elem_mem[load_pos] = 32'(u);
			coef_mem[load_pos] = it.class_prob;
			add = u;
		end else begin
			elem_mem[load_pos] = it.x_value;
			coef_mem[load_pos] = it.sqrt_prob;
			add = round_q15(x * longint'(it.class_prob));
		end
		point_acc[pt] = clamp(point_acc[pt] + add, SUM_LO, SUM_HI);
		load_pos++;
		if (load_pos >= pts * cls) begin
			vec_full = 1'b1;
			load_pos = 0;
		end
	endtask

	task automatic take_read();
		longint             e;
		longint             c;
		longint             acc;
		longint             y;
		ccm_pkg::out_item_t r;
		int                 pt;
		if (!vec_full || read_pos >= pts * cls || read_pos >= STORE_DEPTH) begin
			return;
		end
		pt = read_pos % pts;
		e = longint'(elem_mem[read_pos]);
		c = longint'(coef_mem[read_pos]);
		acc = point_acc[pt];
		if (!xpose) begin
			y = e - round_q15(c * acc);
		end else begin
			y = round_q15(c * (e - acc));
		end
		r.saturated = (y > Y_HI) || (y < Y_LO);
		r.y_value = 32'(clamp(y, Y_LO, Y_HI));
		r.last = (read_pos + 1 == pts * cls);
		read_pos = r.last ? 0 : read_pos + 1;
		owed.push_back(r);
	endtask

	task automatic check_result(input ccm_pkg::out_item_t got);
		ccm_pkg::out_item_t want;
		if (owed.size() == 0) begin
			err_cnt++;
			$display("%0t: unexpected result: expected none, got y_value=%0d last=%0b",
				$time, $signed(got.y_value), got.last, " saturated=%0b", got.saturated);
			return;
		end
		want = owed.pop_front();
		if (got.y_value !== want.y_value || got.last !== want.last
				|| got.saturated !== want.saturated) begin
			err_cnt++;
			$display("%0t: mismatch: expected y_value=%0d last=%0b saturated=%0b,",
				$time, $signed(want.y_value), want.last, want.saturated,
				" got y_value=%0d last=%0b saturated=%0b",
				$signed(got.y_value), got.last, got.saturated);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts = 1;
			cls = 1;
			xpose = 1'b0;
			foreach (point_acc[i]) point_acc[i] = 0;
			restart_vector();
			owed.delete();
		end else begin
			if (out_valid && out_ready) begin
				check_result(out_item);
			end
			if (psel && penable && pwrite && pready) begin
				write_setting(paddr[ccm_pkg::APB_ADDR_W-1:2], pwdata);
			end
			if (in_valid && in_ready) begin
				if (in_item.cmd == ccm_pkg::CMD_LOAD) begin
					take_load(in_item);
				end else begin
					take_read();
				end
			end
		end
		pending <= owed.size();
		failures <= err_cnt;
	end

endmodule

[tb/tb_class_centered_matvec.sv]
`timescale 1ns / 100ps

module tb_class_centered_matvec;

	localparam int                 MAX_POINTS   = 256;
	localparam int                 MAX_CLASSES  = 8;
	localparam int                 ITEM_TARGET  = 1950;
	localparam int                 IDLE_LIMIT   = 1000;
	localparam int                 LATENCY_WAIT = 24;
	localparam logic [1:0]         REG_UNUSED   = 2'd3;
	localparam logic [15:0]        Q15_ONE      = 16'd32768;
	localparam logic signed [31:0] X_MAX        = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] X_MIN        = 32'sh8000_0000;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [ccm_pkg::APB_ADDR_W-1:0] paddr;
	logic [31:0]                    pwdata;
	logic [31:0]                    prdata;
	logic                           pready;
	int                             pending;
	int                             failures;
	logic                           idle_on;
	int                             stall_left = 0;
	int                             idle_cycles = 0;
	int                             cur_pts;
	int                             cur_cls;
	int                             ld_pos;
	logic                           vec_full;
	int                             n_counted;

	ccm_stream_if #(.payload_t(ccm_pkg::in_item_t))  items_in ();
	ccm_stream_if #(.payload_t(ccm_pkg::out_item_t)) results_out ();

	class_centered_matvec #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_CLASSES(MAX_CLASSES)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.stream_in (items_in),
		.stream_out(results_out)
	);

	ccm_result_checker #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_CLASSES(MAX_CLASSES)
	) result_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.in_valid (items_in.valid),
		.in_ready (items_in.ready),
		.in_item  (items_in.payload),
		.out_valid(results_out.valid),
		.out_ready(results_out.ready),
		.out_item (results_out.payload),
		.pending  (pending),
		.failures (failures)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			results_out.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			results_out.ready <= 1'b0;
			stall_left <= $urandom_range(0, 8);
		end else begin
			results_out.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((items_in.valid && items_in.ready) || (results_out.valid && results_out.ready)
					|| (psel && penable && pwrite && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_class_centered_matvec: errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic logic [31:0] pick_x();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 7))
			0: return X_MAX;
			1: return X_MIN;
			2: return 32'($urandom_range(0, 4)) - 32'd2;
			3, 4: return {{11{r[20]}}, r[20:0]};
			default: return r;
		endcase
	endfunction

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return Q15_ONE;
			2: return 16'($urandom());
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	task automatic send_item(input ccm_pkg::in_item_t it);
		int n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 9);
			items_in.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		items_in.valid <= 1'b1;
		items_in.payload <= it;
		do @(posedge clk); while (!items_in.ready);
	endtask

	task automatic send_load(input logic signed [31:0] x, input logic [15:0] p,
			input logic [15:0] s);
		ccm_pkg::in_item_t it;
		it.cmd = ccm_pkg::CMD_LOAD;
		it.x_value = x;
		it.class_prob = p;
		it.sqrt_prob = s;
		if (ld_pos == 0) begin
			vec_full = 1'b0;
		end
		send_item(it);
		n_counted++;
		ld_pos++;
		if (ld_pos == cur_pts * cur_cls) begin
			ld_pos = 0;
			vec_full = 1'b1;
		end
	endtask

	task automatic send_read();
		ccm_pkg::in_item_t it;
		it.cmd = ccm_pkg::CMD_READ;
		it.x_value = $urandom();
		it.class_prob = 16'($urandom());
		it.sqrt_prob = 16'($urandom());
		send_item(it);
		if (vec_full) begin
			n_counted++;
		end
	endtask

	// hold off until every owed result is back and the block has gone quiet
	task automatic settle();
		items_in.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic end_writes();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [8:0] pts_f, input logic [3:0] cls_f, input logic xp);
		logic [31:0] w;
		settle();
		w = $urandom();
		w[8:0] = pts_f;
		write_reg(ccm_pkg::REG_NUM_POINTS, w);
		w = $urandom();
		w[3:0] = cls_f;
		write_reg(ccm_pkg::REG_NUM_CLASSES, w);
		w = $urandom();
		w[0] = xp;
		write_reg(ccm_pkg::REG_TRANSPOSE, w);
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_UNUSED, $urandom());
		end
		end_writes();
		cur_pts = (pts_f == 0) ? 1 : (pts_f > MAX_POINTS) ? MAX_POINTS : int'(pts_f);
		cur_cls = (cls_f == 0) ? 1 : (cls_f > MAX_CLASSES) ? MAX_CLASSES : int'(cls_f);
		ld_pos = 0;
		vec_full = 1'b0;
	endtask

	task automatic exercise_vector(input int rounds);
		int total;
		int n;
		total = cur_pts * cur_cls;
		repeat (rounds) begin
			do begin
				if ($urandom_range(0, 19) == 0) begin
					send_read();
				end
				send_load(pick_x(), pick_coef(), pick_coef());
			end while (ld_pos != 0);
			case ($urandom_range(0, 9))
				0, 1: n = $urandom_range(1, total);
				2: n = total + $urandom_range(1, total);
				default: n = total;
			endcase
			repeat (n) send_read();
			if (total > 1 && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, total - 1);
				repeat (n) begin
					send_load(pick_x(), pick_coef(), pick_coef());
					if ($urandom_range(0, 3) == 0) begin
						send_read();
					end
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		items_in.valid = 1'b0;
		items_in.payload = '0;
		results_out.ready = 1'b0;
		idle_on = 1'b1;
		cur_pts = 1;
		cur_cls = 1;
		ld_pos = 0;
		vec_full = 1'b0;
		n_counted = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_read();
		send_load(X_MAX, 16'd0, 16'hFFFF);
		send_read();
		send_read();

		configure(9'd2, 4'd2, 1'b0);
		send_load(X_MIN, Q15_ONE, Q15_ONE);
		send_load(X_MAX, 16'hFFFF, Q15_ONE);
		send_load(X_MIN, Q15_ONE, 16'hFFFF);
		send_load(-32'sd1, 16'd0, 16'd1);
		send_read();
		settle();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		end_writes();
		repeat (3) send_read();
		send_load(32'sd1, 16'd16384, 16'd1);

		configure(9'd0, 4'd0, 1'b1);
		send_load(X_MAX, 16'd0, 16'hFFFF);
		send_read();
		send_load(X_MIN, 16'hFFFF, 16'hFFFF);
		send_read();
		send_load(-32'sd1, 16'd16384, Q15_ONE);
		send_read();

		n_counted = 0;
		configure(9'd511, 4'd0, 1'($urandom_range(0, 1)));
		exercise_vector(1);
		idle_on <= 1'($urandom_range(0, 1));
		configure(9'd32, 4'd15, 1'($urandom_range(0, 1)));
		exercise_vector(1);
		while (n_counted < ITEM_TARGET) begin
			if (n_counted > ITEM_TARGET * 17 / 20) begin
				idle_on <= 1'b0;
			end else begin
				idle_on <= ($urandom_range(0, 3) != 0);
			end
			configure(9'($urandom_range(0, 8)), 4'($urandom_range(0, 15)),
				1'($urandom_range(0, 1)));
			exercise_vector($urandom_range(1, 3));
		end

		settle();
		if (failures == 0) begin
			$display("tb_class_centered_matvec: clean");
		end else begin
			$display("tb_class_centered_matvec: errors");
		end
		$finish;
	end

endmodule
